### design/sldf_pkg.sv
package sldf_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned CountW = 16;
   localparam int unsigned CrcW   = 32;
   localparam int unsigned StatW  = 2;
   localparam int unsigned DataW  = 56;
   localparam int unsigned UserW  = 3;

   localparam logic [ByteW-1:0]  SyncFirst   = 8'hAA;
   localparam logic [ByteW-1:0]  SyncSecond  = 8'h55;
   localparam logic [CrcW-1:0]   CrcPoly     = 32'hEDB88320;
   localparam logic [CrcW-1:0]   CrcOnes     = 32'hFFFFFFFF;
   localparam logic [CountW-1:0] MinLen      = 16'd10;
   localparam logic [CountW-1:0] MaxLenReset = 16'd8192;

   localparam logic [CountW-1:0] PosIdHi  = 16'd2;
   localparam logic [CountW-1:0] PosIdLo  = 16'd3;
   localparam logic [CountW-1:0] PosLenHi = 16'd4;
   localparam logic [CountW-1:0] PosLenLo = 16'd5;

   localparam logic [StatW-1:0] StatNone   = 2'd0;
   localparam logic [StatW-1:0] StatLenErr = 2'd1;
   localparam logic [StatW-1:0] StatCrcErr = 2'd2;
   localparam logic [StatW-1:0] StatOk     = 2'd3;

   typedef struct packed {
      logic             valid;
      logic [ByteW-1:0] data;
   } stage_type;

   // reflected CRC-32, one byte
   function automatic logic [CrcW-1:0] crc32_byte(input logic [CrcW-1:0] crc,
                                                  input logic [ByteW-1:0] b);
      logic [CrcW-1:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   localparam logic [CrcW-1:0] SyncCrc = crc32_byte(crc32_byte(CrcOnes, SyncFirst), SyncSecond);

endpackage

### design/sync_length_crc32_deframer.sv
// Datapath: each byte passes the input register, then the result register; the result
// register holds its byte while rsp_tready is low.
// Throughput: one byte per cycle while rsp_tready stays high; the byte-wide CRC-32 update
// and position counter sit in the single stage between the two registers.
// Reset: synchronous, active high; hunting, CRC preset to all ones, limit 8192,
// both registers empty.
module sync_length_crc32_deframer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [sldf_pkg::ByteW-1:0]  req_tdata,  // [7:0] data_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [7:0] out_byte, [23:8] byte_index, [39:24] message_id, [55:40] frame_length
   output logic [sldf_pkg::DataW-1:0]  rsp_tdata,
   output logic [sldf_pkg::UserW-1:0]  rsp_tuser,  // [0] byte_in_frame, [2:1] frame_status
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sldf_pkg::CountW-1:0] csr_data    // [15:0] max_frame_len
);
   import sldf_pkg::*;

   logic [CountW-1:0] max_len_ff, max_len_in;
   stage_type         stage;
   logic              advance;

   assign csr_ready  = 1'b1;
   assign max_len_in = (csr_valid && csr_ready) ? csr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxLenReset;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   sldf_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .stage      (stage)
   );

   sldf_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .max_frame_len (max_len_ff),
      .advance       (advance),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser)
   );

   a_hunt_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[23:8] == '0)
      else $error("hunting byte with non-zero index");

   a_status_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] != StatNone |-> rsp_tuser[0])
      else $error("frame status on a hunting byte");

   a_len_err_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] == StatLenErr |-> rsp_tdata[23:8] == PosLenLo)
      else $error("length error away from the length low byte");

   a_no_advance_empty: assert property (@(posedge clock) disable iff (reset)
      advance |-> stage.valid)
      else $error("result stage loaded from an empty input register");

endmodule

### design/sldf_in_reg.sv
module sldf_in_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [sldf_pkg::ByteW-1:0]  req_tdata,
   input  logic                        advance,
   output sldf_pkg::stage_type         stage
);
   import sldf_pkg::*;

   logic             valid_ff, valid_in;
   logic [ByteW-1:0] data_ff, data_in;
   logic             take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req_tdata;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule

### design/sldf_parser.sv
module sldf_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  sldf_pkg::stage_type         stage,
   input  logic [sldf_pkg::CountW-1:0] max_frame_len,
   output logic                        advance,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [sldf_pkg::DataW-1:0]  rsp_tdata,
   output logic [sldf_pkg::UserW-1:0]  rsp_tuser
);
   import sldf_pkg::*;

   logic [ByteW-1:0]  prev_ff, prev_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [CountW-1:0] len_ff, len_in;
   logic [CountW-1:0] id_ff, id_in;
   logic [CrcW-1:0]   crc_ff, crc_in;
   logic [CrcW-1:0]   trailer_ff, trailer_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DataW-1:0]  rsp_data_ff, rsp_data_in;
   logic [UserW-1:0]  rsp_user_ff, rsp_user_in;

   logic [ByteW-1:0]  d;
   logic [CountW-1:0] idx;
   logic              in_frame;
   logic [StatW-1:0]  status;
   logic [CountW:0]   next_count;
   logic [CrcW-1:0]   crc_step;

   assign advance = stage.valid && (!rsp_valid_ff || rsp_tready);
   assign d       = stage.data;

   assign next_count = {1'b0, count_ff} + {{CountW{1'b0}}, 1'b1};
   assign crc_step   = crc32_byte(crc_ff, d);

   always_comb begin
      prev_in    = prev_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      id_in      = id_ff;
      crc_in     = crc_ff;
      trailer_in = trailer_ff;
      idx        = '0;
      in_frame   = 1'b0;
      status     = StatNone;
      if (count_ff == '0) begin
         if (prev_ff == SyncFirst && d == SyncSecond) begin
            count_in   = 16'd2;
            crc_in     = SyncCrc;
            trailer_in = '0;
            id_in      = '0;
            len_in     = '0;
            idx        = 16'd1;
            in_frame   = 1'b1;
         end
         prev_in = d;
      end else begin
         idx      = count_ff;
         in_frame = 1'b1;
         count_in = next_count[CountW-1:0];
         case (count_ff)
            PosIdHi:  id_in  = {d, 8'd0};
            PosIdLo:  id_in  = {id_ff[15:8], d};
            PosLenHi: len_in = {d, 8'd0};
            PosLenLo: len_in = {len_ff[15:8], d};
            default: ;
         endcase
         if (count_ff < 16'd6 ||
             ({1'b0, count_ff} + 17'd4) < {1'b0, len_in}) begin
            crc_in = crc_step;
         end else begin
            trailer_in = {trailer_ff[23:0], d};
         end
         if (count_ff == PosLenLo) begin
            if (len_in > max_frame_len || len_in < MinLen) begin
               status   = StatLenErr;
               count_in = '0;
               prev_in  = '0;
            end
         end else if (count_ff > PosLenLo && next_count >= {1'b0, len_in}) begin
            status   = ((crc_in ^ CrcOnes) == trailer_in) ? StatOk : StatCrcErr;
            count_in = '0;
            prev_in  = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {len_in, id_in, idx, d};
         rsp_user_in  = {status, in_frame};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         count_ff     <= '0;
         len_ff       <= '0;
         id_ff        <= '0;
         crc_ff       <= CrcOnes;
         trailer_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            prev_ff    <= prev_in;
            count_ff   <= count_in;
            len_ff     <= len_in;
            id_ff      <= id_in;
            crc_ff     <= crc_in;
            trailer_ff <= trailer_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### dv/deframer_tb_pkg.sv
package deframer_tb_pkg;

   import sldf_pkg::*;

   typedef struct packed {
      logic [ByteW-1:0]  out_byte;
      logic [CountW-1:0] byte_index;
      logic              in_frame;
      logic [StatW-1:0]  status;
      logic [CountW-1:0] msg_id;
      logic [CountW-1:0] frame_len;
   } deframe_out_t;

   // reflected CRC-32, bit-serial over one byte
   function automatic logic [CrcW-1:0] crc32_update(input logic [CrcW-1:0] acc,
                                                    input logic [ByteW-1:0] b);
      logic [CrcW-1:0] r;
      r = acc;
      for (int k = 0; k < ByteW; k++) begin
         if (r[0] ^ b[k]) r = (r >> 1) ^ CrcPoly;
         else r = r >> 1;
      end
      return r;
   endfunction

endpackage

### dv/deframer_checker.sv
module deframer_checker
   import sldf_pkg::*;
   import deframer_tb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [ByteW-1:0]  req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [DataW-1:0]  rsp_tdata,
   input  logic [UserW-1:0]  rsp_tuser,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CountW-1:0] csr_data,
   output int                fail_count,
   output int                results_left
);

   logic [CountW-1:0] max_len;
   logic [ByteW-1:0]  prev_byte;
   logic [CountW-1:0] rx_count;
   logic [CountW-1:0] decl_len;
   logic [CountW-1:0] id_reg;
   logic [CrcW-1:0]   crc_acc;
   logic [CrcW-1:0]   trailer;

   deframe_out_t pending_results[$];
   int           mism;

   function automatic deframe_out_t deframe_step(input logic [ByteW-1:0] d);
      deframe_out_t      r;
      logic [CountW-1:0] pos;
      logic [CountW:0]   count;
      r = '0;
      r.out_byte = d;
      r.status = StatNone;
      if (rx_count == 0) begin
         if (prev_byte == SyncFirst && d == SyncSecond) begin
            rx_count = 16'd2;
            crc_acc = crc32_update(crc32_update(CrcOnes, SyncFirst), SyncSecond);
            trailer = '0;
            id_reg = '0;
            decl_len = '0;
            r.byte_index = 16'd1;
            r.in_frame = 1'b1;
         end
         prev_byte = d;
      end else begin
         pos = rx_count;
         count = {1'b0, pos} + 17'd1;
         r.byte_index = pos;
         r.in_frame = 1'b1;
         rx_count = count[CountW-1:0];
         case (pos)
            PosIdHi:  id_reg = {d, 8'h00};
            PosIdLo:  id_reg = id_reg | {8'h00, d};
            PosLenHi: decl_len = {d, 8'h00};
            PosLenLo: decl_len = decl_len | {8'h00, d};
            default: ;
         endcase
         if (pos <= PosLenLo || ({1'b0, pos} + 17'd4) < {1'b0, decl_len})
            crc_acc = crc32_update(crc_acc, d);
         else
            trailer = {trailer[CrcW-9:0], d};
         if (pos == PosLenLo) begin
            if (decl_len > max_len || decl_len < MinLen) begin
               r.status = StatLenErr;
               rx_count = '0;
               prev_byte = '0;
            end
         end else if (pos > PosLenLo && count >= {1'b0, decl_len}) begin
            r.status = ((crc_acc ^ CrcOnes) == trailer) ? StatOk : StatCrcErr;
            rx_count = '0;
            prev_byte = '0;
         end
      end
      r.msg_id = id_reg;
      r.frame_len = decl_len;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mism++;
      end
   endtask

   always @(posedge clock) begin
      deframe_out_t want;
      deframe_out_t got;
      if (reset) begin
         max_len = MaxLenReset;
         prev_byte = '0;
         rx_count = '0;
         decl_len = '0;
         id_reg = '0;
         crc_acc = CrcOnes;
         trailer = '0;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) max_len = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte   = rsp_tdata[7:0];
            got.byte_index = rsp_tdata[23:8];
            got.msg_id     = rsp_tdata[39:24];
            got.frame_len  = rsp_tdata[55:40];
            got.in_frame   = rsp_tuser[0];
            got.status     = rsp_tuser[2:1];
            if (pending_results.size() == 0) begin
               $error("result transfer with nothing outstanding");
               mism++;
            end else begin
               want = pending_results.pop_front();
               check_field("out_byte", want.out_byte, got.out_byte);
               check_field("byte_index", want.byte_index, got.byte_index);
               check_field("byte_in_frame", want.in_frame, got.in_frame);
               check_field("frame_status", want.status, got.status);
               check_field("message_id", want.msg_id, got.msg_id);
               check_field("frame_length", want.frame_len, got.frame_len);
            end
         end
         if (req_tvalid && req_tready) pending_results.push_back(deframe_step(req_tdata));
      end
      fail_count <= mism;
      results_left <= pending_results.size();
   end

endmodule

### dv/tb_top.sv
module tb_top;

   import sldf_pkg::*;
   import deframer_tb_pkg::*;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [ByteW-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DataW-1:0]  rsp_tdata;
   logic [UserW-1:0]  rsp_tuser;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CountW-1:0] csr_data = '0;

   int                fail_count;
   int                results_left;
   bit                idle_on = 1'b1;
   int                bytes_sent;
   logic [CountW-1:0] cur_limit = MaxLenReset;

   sync_length_crc32_deframer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   deframer_checker u_chk (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .results_left (results_left)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(4 * 10_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   // receive side back-pressure
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [ByteW-1:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 14)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // frame with header, random body and big-endian CRC trailer; a length the
   // block will reject stops after the header; cut truncates the frame
   task automatic send_frame(input logic [CountW-1:0] id, input logic [CountW-1:0] len,
                             input bit bad_crc, input int cut);
      logic [ByteW-1:0] b;
      logic [CrcW-1:0]  acc;
      logic [CrcW-1:0]  flip;
      int               n;
      acc = CrcOnes;
      flip = bad_crc ? (32'h1 << $urandom_range(0, 31)) : '0;
      n = (len < MinLen || len > cur_limit) ? 6 : int'(len);
      for (int i = 0; i < n; i++) begin
         if (cut != 0 && i >= cut) break;
         case (i)
            0: b = SyncFirst;
            1: b = SyncSecond;
            2: b = id[15:8];
            3: b = id[7:0];
            4: b = len[15:8];
            5: b = len[7:0];
            default: b = 8'($urandom);
         endcase
         if (i >= 6 && i >= int'(len) - 4)
            b = 8'((acc ^ CrcOnes ^ flip) >> (8 * (int'(len) - 1 - i)));
         else
            acc = crc32_update(acc, b);
         send_byte(b);
      end
   endtask

   task automatic send_noise(input int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 5);
         if (pick < 2) send_byte(SyncFirst);
         else if (pick == 2) send_byte(SyncSecond);
         else send_byte(8'($urandom));
      end
   endtask

   task automatic write_limit(input logic [CountW-1:0] v);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_left != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_limit = v;
   endtask

   task automatic random_traffic(input int target);
      int               sel;
      logic [CountW-1:0] bad_len;
      bytes_sent = 0;
      while (bytes_sent < target) begin
         sel = $urandom_range(0, 99);
         if (sel < 65) begin
            send_frame(16'($urandom), 16'($urandom_range(10, 26)),
                       $urandom_range(0, 5) == 0, 0);
         end else if (sel < 77) begin
            if (cur_limit < 16'hFFFF && $urandom_range(0, 1) == 1)
               bad_len = 16'($urandom_range(int'(cur_limit) + 1, 65535));
            else
               bad_len = 16'($urandom_range(0, 9));
            send_frame(16'($urandom), bad_len, 1'b0, 0);
         end else if (sel < 87) begin
            send_frame(16'($urandom), 16'($urandom_range(10, 26)), 1'b0,
                       $urandom_range(1, 9));
         end else begin
            send_noise($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset limit: shortest frame, oversize length ending in 0xAA,
      // stray 0x55 after it, double 0xAA before a sync, undersize length
      send_frame(16'h0000, 16'd10, 1'b0, 0);
      send_frame(16'hFFFF, 16'hFFAA, 1'b0, 0);
      send_byte(SyncSecond);
      send_byte(8'hFF);
      send_byte(SyncFirst);
      send_frame(16'h1234, 16'd9, 1'b0, 0);

      write_limit(16'd10);
      send_frame(16'($urandom), 16'd10, 1'b0, 0);
      send_frame(16'($urandom), 16'd11, 1'b0, 0);
      send_frame(16'($urandom), 16'd10, 1'b1, 0);

      write_limit(16'd9);
      send_frame(16'($urandom), 16'd10, 1'b0, 0);

      write_limit(16'hFFFF);
      send_frame(16'hA55A, 16'd64, 1'b0, 0);
      send_frame(16'($urandom), 16'd10, 1'b0, 0);

      write_limit(MaxLenReset);
      random_traffic(130);
      write_limit(16'($urandom_range(10, 40)));
      random_traffic(110);
      write_limit(16'($urandom_range(10, 65535)));
      idle_on = 1'b0;
      random_traffic(60);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_left != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && results_left == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
